>>> rtl/omniik_pkg.sv
// ----------------------------------------------------------------------------
// omniik_pkg
// Shared types, constants and helpers of the omni wheel inverse kinematics:
// cordic arctangent table, slot tag carried down the cell row, saturation.
// ----------------------------------------------------------------------------
package omniik_pkg;

	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_COUNT        = 24;

	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int MAG_W     = 14;
	localparam int SPIN_W    = 52;
	localparam int HI_W      = 28;
	localparam int WHEELS    = 4;

	localparam logic [MAG_W-1:0]      LIMIT_RESET    = 14'd16383;
	localparam logic [7:0]            WHEEL_ID_BASE  = 8'd2;
	localparam logic [1:0]            WHEEL_LAST     = 2'(WHEELS - 1);
	localparam logic signed [31:0]    CORDIC_K       = 32'sh26DD3B6A;
	localparam logic signed [31:0]    QUARTER_TURN   = 32'sh4000_0000;
	localparam logic signed [63:0]    SAT_BOUND      = 64'sh0004_0000_0000_0000;

	localparam logic [31:0] ATAN_TURNS [ATAN_COUNT] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20860,
		32'd10430,     32'd5215,      32'd2607,      32'd1303,
		32'd651,       32'd325,       32'd162,       32'd81
	};

	typedef enum logic [1:0] {
		DIR_CCW   = 2'd0,
		DIR_CW    = 2'd1,
		DIR_BRAKE = 2'd2
	} dir_t;

	typedef enum logic {
		REG_ROTATION_ARM = 1'b0,
		REG_SPEED_LIMIT  = 1'b1
	} reg_t;

	typedef struct packed {
		logic       test;
		logic [7:0] wid;
		logic       last;
	} meta_t;

	typedef struct packed {
		meta_t                    meta;
		logic                     neg;
		logic signed [31:0]       speed;
		logic signed [SPIN_W-1:0] spin;
	} tag_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec_t;

	function automatic logic signed [SPIN_W-1:0] sat_q32(input logic signed [63:0] v);
		logic signed [63:0] r;
		if (v > SAT_BOUND) begin
			r = SAT_BOUND;
		end else if (v < -SAT_BOUND) begin
			r = -SAT_BOUND;
		end else begin
			r = v;
		end
		return SPIN_W'(r);
	endfunction

endpackage

>>> rtl/omniik_cell.sv
// ----------------------------------------------------------------------------
// omniik_cell
// One cordic rotation cell: a fixed shift and arctangent step, registered,
// passing its vector and slot tag to the next cell on every advance.
// ----------------------------------------------------------------------------
module omniik_cell #(
	parameter int STAGE = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               prev_valid,
	input  omniik_pkg::tag_t   prev_tag,
	input  omniik_pkg::vec_t   prev_vec,
	output logic               next_valid,
	output omniik_pkg::tag_t   next_tag,
	output omniik_pkg::vec_t   next_vec
);
	import omniik_pkg::*;

	localparam logic signed [31:0] ANGLE = $signed(ATAN_TURNS[STAGE]);

	logic               valid_q;
	tag_t               tag_q;
	vec_t               vec_q;
	vec_t               rot;
	logic signed [31:0] xs;
	logic signed [31:0] ys;

	always_comb begin
		xs = prev_vec.x >>> STAGE;
		ys = prev_vec.y >>> STAGE;
		if (!prev_vec.z[31]) begin
			rot.x = prev_vec.x - ys;
			rot.y = prev_vec.y + xs;
			rot.z = prev_vec.z - ANGLE;
		end else begin
			rot.x = prev_vec.x + ys;
			rot.y = prev_vec.y - xs;
			rot.z = prev_vec.z + ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_q <= prev_tag;
			vec_q <= rot;
		end
	end

	assign next_valid = valid_q;
	assign next_tag   = tag_q;
	assign next_vec   = vec_q;

endmodule

>>> rtl/omniik_issue.sv
// ----------------------------------------------------------------------------
// omniik_issue
// Item holding register and wheel sequencer: takes one item, issues one slot
// per wheel (or one for a test item) into the cell row with folded angle.
// ----------------------------------------------------------------------------
module omniik_issue #(
	parameter int ANGLE_BITS = omniik_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [31:0]        rotation_arm,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               cmd,
	input  logic signed [31:0] travel_speed,
	input  logic [15:0]        travel_heading,
	input  logic [15:0]        attitude,
	input  logic signed [31:0] angular_rate,
	input  logic [7:0]         test_wheel,
	input  logic signed [31:0] test_speed,
	output logic               slot_valid,
	output omniik_pkg::tag_t   slot_tag,
	output omniik_pkg::vec_t   slot_vec
);
	import omniik_pkg::*;

	logic                    busy_q;
	logic [1:0]              k_q;
	logic                    test_q;
	logic signed [31:0]      speed_q;
	logic [ANGLE_BITS-1:0]   base_q;
	logic [7:0]              wid_q;
	logic signed [63:0]      prod_q;

	logic                    last_slot;
	logic                    accept;
	logic [ANGLE_BITS-1:0]   phi;
	logic signed [31:0]      turn;

	assign last_slot  = test_q || (k_q == WHEEL_LAST);
	assign item_ready = !busy_q || (adv && last_slot);
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (busy_q && adv) begin
			if (last_slot) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			test_q  <= cmd;
			speed_q <= cmd ? test_speed : travel_speed;
			base_q  <= ANGLE_BITS'(travel_heading) - ANGLE_BITS'(attitude);
			wid_q   <= test_wheel;
			prod_q  <= $signed({angular_rate[31], angular_rate}) * $signed({1'b0, rotation_arm});
		end
	end

	always_comb begin
		phi  = base_q - {k_q, 1'b1, {(ANGLE_BITS-3){1'b0}}};
		turn = $signed({phi, {(32-ANGLE_BITS){1'b0}}});

		slot_vec.x   = CORDIC_K;
		slot_vec.y   = '0;
		slot_tag.neg = 1'b0;
		if (turn > QUARTER_TURN) begin
			slot_vec.z   = {~turn[31], turn[30:0]};
			slot_tag.neg = 1'b1;
		end else if (turn < -QUARTER_TURN) begin
			slot_vec.z   = {~turn[31], turn[30:0]};
			slot_tag.neg = 1'b1;
		end else begin
			slot_vec.z = turn;
		end

		slot_tag.meta.test = test_q;
		slot_tag.meta.wid  = test_q ? wid_q : WHEEL_ID_BASE + 8'(k_q);
		slot_tag.meta.last = last_slot;
		slot_tag.speed     = speed_q;
		slot_tag.spin      = test_q ? '0 : sat_q32(prod_q);
	end

	assign slot_valid = busy_q;

endmodule

>>> rtl/omniik_post.sv
// ----------------------------------------------------------------------------
// omniik_post
// Wheel value back end: speed times cosine (speed alone for a test item),
// truncation, rotation term, saturation, scaling by 1000 for chassis items,
// direction and limited magnitude.
module omniik_post (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         cos_valid,
	input  omniik_pkg::tag_t             cos_tag,
	input  logic signed [31:0]           cos_x,
	input  logic [omniik_pkg::MAG_W-1:0] speed_limit,
	output logic                         result_valid,
	output logic [7:0]                   wheel_id,
	output logic [1:0]                   turn_direction,
	output logic [omniik_pkg::MAG_W-1:0] speed_magnitude,
	output logic                         last
);
	import omniik_pkg::*;

	localparam int A_W     = SPIN_W - 1;
	localparam int SCALE_W = A_W + 10;
	localparam logic signed [63:0] TRUNC_BIAS = 64'sd16383;

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_q;
	meta_t                    meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic signed [SPIN_W-1:0] spin_s1, spin_s2;
	logic signed [63:0]       p_s1;
	logic signed [SPIN_W-1:0] lin_s2;
	logic signed [SPIN_W-1:0] s_s3;
	dir_t                     dir_s4, dir_s5, dir_q;
	logic [A_W-1:0]           a_s4;
	logic [HI_W-1:0]          hi_s5;
	logic [7:0]               wid_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     last_q;

	logic signed [31:0]       cs;
	logic signed [63:0]       prod;
	logic signed [63:0]       lin;
	logic signed [63:0]       sum;
	logic                     s_neg;
	logic [SCALE_W-1:0]       scaled;

	always_comb begin
		cs     = cos_tag.neg ? -cos_x : cos_x;
		prod   = cos_tag.meta.test ? (64'(cos_tag.speed) <<< 14) : cos_tag.speed * cs;
		lin    = (p_s1 + (p_s1[63] ? TRUNC_BIAS : 64'sd0)) >>> 14;
		sum    = 64'(lin_s2) + 64'(spin_s2);
		s_neg  = s_s3[SPIN_W-1];
		scaled = (SCALE_W'(a_s4) << 10) - (SCALE_W'(a_s4) << 4) - (SCALE_W'(a_s4) << 3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cos_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_q  <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= cos_tag.meta;
			spin_s1 <= cos_tag.spin;
			p_s1    <= prod;

			meta_s2 <= meta_s1;
			spin_s2 <= spin_s1;
			lin_s2  <= SPIN_W'(lin);

			meta_s3 <= meta_s2;
			s_s3    <= sat_q32(sum);

			meta_s4 <= meta_s3;
			if (s_neg) begin
				dir_s4 <= DIR_CW;
			end else if (s_s3 == '0) begin
				dir_s4 <= DIR_BRAKE;
			end else begin
				dir_s4 <= DIR_CCW;
			end
			a_s4 <= A_W'(s_neg ? -s_s3 : s_s3);

			meta_s5 <= meta_s4;
			dir_s5  <= dir_s4;
			hi_s5   <= meta_s4.test ? HI_W'(a_s4 >> 16) : HI_W'(scaled >> 32);

			wid_q  <= meta_s5.wid;
			last_q <= meta_s5.last;
			dir_q  <= dir_s5;
			mag_q  <= (hi_s5 > HI_W'(speed_limit)) ? speed_limit : MAG_W'(hi_s5);
		end
	end

	assign result_valid    = valid_q;
	assign wheel_id        = wid_q;
	assign turn_direction  = dir_q;
	assign speed_magnitude = mag_q;
	assign last            = last_q;

endmodule

>>> rtl/omni_wheel_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// omni_wheel_inverse_kinematics
// Four wheel omni drive: chassis command to per wheel direction and speed,
// cosine from a row of cordic cells, plus a single wheel test path.
//
//   channel   side   handshake                    payload
//   item      in     item_valid / item_ready      cmd .. test_speed
//   result    out    result_valid / result_ready  wheel_id .. last
//   config    in     apb (psel, penable, ...)     rotation_arm, speed_limit
//
// a chassis item issues one wheel slot per cycle unless stalled, a test item one slot
// first result valid once the slot has passed the cell row and the back end registers
// arst_n clears valids, sequencer and registers (rotation_arm 0, limit 16383)
// a held result freezes the whole pipeline until result_ready
// ----------------------------------------------------------------------------
module omni_wheel_inverse_kinematics #(
	parameter int ANGLE_BITS    = omniik_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = omniik_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [omniik_pkg::ADDR_W-1:0] paddr,
	input  logic [omniik_pkg::DATA_W-1:0] pwdata,
	output logic [omniik_pkg::DATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          cmd,
	input  logic signed [31:0]            travel_speed,
	input  logic [15:0]                   travel_heading,
	input  logic [15:0]                   attitude,
	input  logic signed [31:0]            angular_rate,
	input  logic [7:0]                    test_wheel,
	input  logic signed [31:0]            test_speed,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [7:0]                    wheel_id,
	output logic [1:0]                    turn_direction,
	output logic [omniik_pkg::MAG_W-1:0]  speed_magnitude,
	output logic                          last
);
	import omniik_pkg::*;

	logic [31:0]      arm_q;
	logic [MAG_W-1:0] limit_q;
	reg_t             reg_idx;
	logic             wr;
	logic             adv;

	logic             valid_c [CORDIC_STAGES+1];
	tag_t             tag_c   [CORDIC_STAGES+1];
	vec_t             vec_c   [CORDIC_STAGES+1];

	assign pready  = 1'b1;
	assign reg_idx = reg_t'(paddr[2]);
	assign wr      = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_q   <= '0;
			limit_q <= LIMIT_RESET;
		end else if (wr) begin
			unique case (reg_idx)
				REG_ROTATION_ARM: arm_q   <= pwdata;
				REG_SPEED_LIMIT:  limit_q <= MAG_W'(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROTATION_ARM: prdata = arm_q;
			REG_SPEED_LIMIT:  prdata = DATA_W'(limit_q);
			default:          prdata = '0;
		endcase
	end

	assign adv = !result_valid || result_ready;

	omniik_issue #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_issue (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.rotation_arm  (arm_q),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.cmd           (cmd),
		.travel_speed  (travel_speed),
		.travel_heading(travel_heading),
		.attitude      (attitude),
		.angular_rate  (angular_rate),
		.test_wheel    (test_wheel),
		.test_speed    (test_speed),
		.slot_valid    (valid_c[0]),
		.slot_tag      (tag_c[0]),
		.slot_vec      (vec_c[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		omniik_cell #(
			.STAGE(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.prev_valid(valid_c[i]),
			.prev_tag  (tag_c[i]),
			.prev_vec  (vec_c[i]),
			.next_valid(valid_c[i+1]),
			.next_tag  (tag_c[i+1]),
			.next_vec  (vec_c[i+1])
		);
	end

	omniik_post u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.cos_valid      (valid_c[CORDIC_STAGES]),
		.cos_tag        (tag_c[CORDIC_STAGES]),
		.cos_x          (vec_c[CORDIC_STAGES].x),
		.speed_limit    (limit_q),
		.result_valid   (result_valid),
		.wheel_id       (wheel_id),
		.turn_direction (turn_direction),
		.speed_magnitude(speed_magnitude),
		.last           (last)
	);

`ifndef SYNTHESIS
	a_brake_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (turn_direction == DIR_BRAKE) |-> speed_magnitude == '0)
		else $error("brake result with nonzero magnitude");

	a_chassis_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && !cmd |=> !item_ready)
		else $error("chassis item did not hold off the next item");

	a_inner_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |->
			(wheel_id == 8'd2) || (wheel_id == 8'd3) || (wheel_id == 8'd4))
		else $error("non-final result with unexpected wheel id");
`endif

endmodule
